// ===== src/lrs_pkg.sv =====
// Shared types, constants and codes for the RGB LED strip serializer.
// No dependencies; every other file refers to it by scoped names.
package lrs_pkg;

    // default strip length and color layout
    localparam int LED_COUNT_DEF = 64;
    localparam int BITS_PER_LED  = 24;
    localparam int BIT_SEL_W     = $clog2(BITS_PER_LED);

    // register reset values
    localparam logic [7:0] PERIOD_RST    = 8'd29;
    localparam logic [7:0] ONE_HIGH_RST  = 8'd17;
    localparam logic [7:0] ZERO_HIGH_RST = 8'd9;
    localparam logic [7:0] LATCH_RST     = 8'd42;

    // request operation codes
    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PERIOD    = 2'd0,
        CFG_ONE_HIGH  = 2'd1,
        CFG_ZERO_HIGH = 2'd2,
        CFG_LATCH     = 2'd3
    } cfg_idx_t;

    typedef logic [BITS_PER_LED-1:0] color_t;

    // input request payload
    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       show_after;
    } item_t;

    // result payload
    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
    } result_t;

    // configuration register file
    typedef struct packed {
        logic [7:0] slot_period_minus_one;
        logic [7:0] one_high_ticks;
        logic [7:0] zero_high_ticks;
        logic [7:0] latch_slots;
    } cfg_t;

    // per-request status handed from the sequencer to the result stage
    typedef struct packed {
        logic                 drive;      // tick in a data slot of a written LED
        logic                 high_one;   // tick count below the one-bit high time
        logic                 high_zero;  // tick count below the zero-bit high time
        logic [BIT_SEL_W-1:0] bit_sel;    // bit of the color word for this slot
        logic                 busy;
        logic                 done;
    } slot_info_t;

endpackage

// ===== src/lrs_color_mem.sv =====
// Color store: one 24-bit word per LED, one write and one read port.
// Read data is registered. Depends on lrs_pkg.
module lrs_color_mem #(
    parameter int LED_COUNT = lrs_pkg::LED_COUNT_DEF,
    parameter int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  lrs_pkg::color_t     wr_data,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output lrs_pkg::color_t     rd_data
);

    lrs_pkg::color_t mem [LED_COUNT];
    lrs_pkg::color_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/lrs_frame_ctrl.sv =====
// Frame sequencer: slot and tick counters, written flags, color store writes
// and read addressing. Depends on lrs_pkg.
module lrs_frame_ctrl #(
    parameter int LED_COUNT = lrs_pkg::LED_COUNT_DEF,
    parameter int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  lrs_pkg::item_t        item,
    input  lrs_pkg::cfg_t         cfg,
    output logic                  wr_en,
    output logic [IDX_W-1:0]      wr_addr,
    output lrs_pkg::color_t       wr_data,
    output logic                  rd_en,
    output logic [IDX_W-1:0]      rd_addr,
    output lrs_pkg::slot_info_t   info
);

    localparam int DATA_SLOTS = LED_COUNT * lrs_pkg::BITS_PER_LED;
    localparam int SLOT_W     = $clog2(DATA_SLOTS + 256);
    localparam int PTR_W      = $clog2(LED_COUNT + 1);
    localparam int BW         = lrs_pkg::BIT_SEL_W;

    logic                 sending_reg,  sending_next;
    logic [SLOT_W-1:0]    slot_reg,     slot_next;
    logic [7:0]           tick_reg,     tick_next;
    logic [PTR_W-1:0]     led_ptr_reg,  led_ptr_next;
    logic [BW-1:0]        bit_ptr_reg,  bit_ptr_next;
    logic [LED_COUNT-1:0] written_reg,  written_next;

    logic              idx_ok;
    logic              is_set;
    logic              is_tick;
    logic              start_req;
    logic              data_slot;
    logic              slot_end;
    logic [SLOT_W-1:0] slot_inc;
    logic [SLOT_W-1:0] total_slots;
    logic              frame_end;

    // request decode
    assign idx_ok    = {1'b0, item.led_index} < 9'(LED_COUNT);
    assign is_set    = (item.operation == lrs_pkg::OP_SET) && idx_ok;
    assign is_tick   = (item.operation == lrs_pkg::OP_TICK) && sending_reg;
    assign start_req = (is_set && item.show_after) || (item.operation == lrs_pkg::OP_START);

    // slot bookkeeping
    assign data_slot   = slot_reg < SLOT_W'(DATA_SLOTS);
    assign slot_end    = tick_reg >= cfg.slot_period_minus_one;
    assign slot_inc    = slot_reg + SLOT_W'(1);
    assign total_slots = SLOT_W'(DATA_SLOTS) + SLOT_W'(cfg.latch_slots);
    assign frame_end   = slot_end && (slot_inc >= total_slots);

    // color store ports
    assign wr_en   = accept && is_set;
    assign wr_addr = item.led_index[IDX_W-1:0];
    assign wr_data = {item.green, item.red, item.blue};
    assign rd_en   = accept && is_tick && data_slot;
    assign rd_addr = led_ptr_reg[IDX_W-1:0];

    // counter and flag updates
    always_comb
    begin
        sending_next = sending_reg;
        slot_next    = slot_reg;
        tick_next    = tick_reg;
        led_ptr_next = led_ptr_reg;
        bit_ptr_next = bit_ptr_reg;
        written_next = written_reg;
        if (accept)
        begin
            if (is_set)
            begin
                written_next[item.led_index[IDX_W-1:0]] = 1'b1;
            end
            if (start_req && !sending_reg)
            begin
                sending_next = 1'b1;
                slot_next    = '0;
                tick_next    = '0;
                led_ptr_next = '0;
                bit_ptr_next = '0;
            end
            else if (is_tick)
            begin
                if (!slot_end)
                begin
                    tick_next = tick_reg + 8'd1;
                end
                else if (frame_end)
                begin
                    tick_next    = '0;
                    sending_next = 1'b0;
                    slot_next    = '0;
                    led_ptr_next = '0;
                    bit_ptr_next = '0;
                end
                else
                begin
                    tick_next = '0;
                    slot_next = slot_inc;
                    if (data_slot)
                    begin
                        if (bit_ptr_reg == BW'(lrs_pkg::BITS_PER_LED - 1))
                        begin
                            bit_ptr_next = '0;
                            led_ptr_next = led_ptr_reg + PTR_W'(1);
                        end
                        else
                        begin
                            bit_ptr_next = bit_ptr_reg + BW'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg <= 1'b0;
            slot_reg    <= '0;
            tick_reg    <= '0;
            led_ptr_reg <= '0;
            bit_ptr_reg <= '0;
            written_reg <= '0;
        end
        else
        begin
            sending_reg <= sending_next;
            slot_reg    <= slot_next;
            tick_reg    <= tick_next;
            led_ptr_reg <= led_ptr_next;
            bit_ptr_reg <= bit_ptr_next;
            written_reg <= written_next;
        end
    end

    // status for the result stage, taken with the request
    always_comb
    begin
        info.drive     = is_tick && data_slot && written_reg[rd_addr];
        info.high_one  = tick_reg < cfg.one_high_ticks;
        info.high_zero = tick_reg < cfg.zero_high_ticks;
        info.bit_sel   = BW'(lrs_pkg::BITS_PER_LED - 1) - bit_ptr_reg;
        info.busy      = sending_next;
        info.done      = is_tick && frame_end;
    end

endmodule

// ===== src/rgb_led_strip_serializer.sv =====
// Top level of the RGB LED strip serializer: handshakes, configuration
// registers and result stage. Depends on lrs_pkg, lrs_frame_ctrl, lrs_color_mem.
//
//  channel  direction  handshake              payload
//  item     in         item_valid/item_stall  lrs_pkg::item_t
//  result   out        result_valid/stall     lrs_pkg::result_t
//  cfg      in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One request per clock unless the result stalls; each result is registered,
// set by the registered read of the color store that feeds the line level.
// Reset clears counters, written flags and registers; color words need no
// clearing since an LED without its written flag never drives the line.
// A stalled result holds the result stage and stalls the item channel.
module rgb_led_strip_serializer #(
    parameter int LED_COUNT = lrs_pkg::LED_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  lrs_pkg::item_t     item,
    output logic               result_valid,
    input  logic               result_stall,
    output lrs_pkg::result_t   result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    lrs_pkg::cfg_t        cfg_reg;
    lrs_pkg::slot_info_t  info;
    lrs_pkg::slot_info_t  info_reg;
    logic                 valid_reg;
    logic                 accept;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    lrs_pkg::color_t      wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    lrs_pkg::color_t      rd_data;
    logic                 color_bit;

    // handshake
    assign item_stall = valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slot_period_minus_one <= lrs_pkg::PERIOD_RST;
            cfg_reg.one_high_ticks        <= lrs_pkg::ONE_HIGH_RST;
            cfg_reg.zero_high_ticks       <= lrs_pkg::ZERO_HIGH_RST;
            cfg_reg.latch_slots           <= lrs_pkg::LATCH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (lrs_pkg::cfg_idx_t'(cfg_index))
                lrs_pkg::CFG_PERIOD:    cfg_reg.slot_period_minus_one <= cfg_data;
                lrs_pkg::CFG_ONE_HIGH:  cfg_reg.one_high_ticks        <= cfg_data;
                lrs_pkg::CFG_ZERO_HIGH: cfg_reg.zero_high_ticks       <= cfg_data;
                lrs_pkg::CFG_LATCH:     cfg_reg.latch_slots           <= cfg_data;
                default:                cfg_reg                       <= cfg_reg;
            endcase
        end
    end

    lrs_frame_ctrl #(
        .LED_COUNT (LED_COUNT),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (item),
        .cfg     (cfg_reg),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .info    (info)
    );

    lrs_color_mem #(
        .LED_COUNT (LED_COUNT),
        .IDX_W     (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            valid_reg <= item_valid;
        end
    end

    // result stage status, aligned with the color read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            info_reg <= info;
        end
    end

    // line level from the color bit of the current slot
    assign color_bit = rd_data[info_reg.bit_sel];

    always_comb
    begin
        result.line_level = info_reg.drive &&
                            (color_bit ? info_reg.high_one : info_reg.high_zero);
        result.busy_res   = info_reg.busy;
        result.frame_done = info_reg.done;
    end

    assign result_valid = valid_reg;

endmodule

// ===== dv/tb_rgb_led_strip_serializer.sv =====
// Testbench for rgb_led_strip_serializer: directed, long-slot and random requests
// checked against an in-bench predictor of the strip line. Depends on lrs_pkg and the RTL.
`timescale 1ns / 1ps

module tb_rgb_led_strip_serializer;

    localparam int          LEDS        = lrs_pkg::LED_COUNT_DEF;
    localparam int          DATA_SLOTS  = LEDS * lrs_pkg::BITS_PER_LED;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int          CYCLE_LIMIT = 200000;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    lrs_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    lrs_pkg::result_t result;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index    = '0;
    logic [7:0]       cfg_data     = '0;

    // predicted strip state
    lrs_pkg::color_t led_rgb [LEDS] = '{default: '0};
    bit              led_lit [LEDS] = '{default: 1'b0};
    bit              frame_on  = 1'b0;
    int unsigned     slot_pos  = 0;
    int unsigned     slot_tick = 0;
    lrs_pkg::cfg_t   regs      = '{lrs_pkg::PERIOD_RST, lrs_pkg::ONE_HIGH_RST,
                                   lrs_pkg::ZERO_HIGH_RST, lrs_pkg::LATCH_RST};

    lrs_pkg::result_t line_results_due [$];
    int               fail_count  = 0;
    int               cycle_count = 0;
    bit               idle_on     = 1'b1;

    rgb_led_strip_serializer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // predictor
    function automatic void begin_frame();
        if (!frame_on)
        begin
            frame_on  = 1'b1;
            slot_pos  = 0;
            slot_tick = 0;
        end
    endfunction

    function automatic lrs_pkg::result_t strip_step(input lrs_pkg::item_t it);
        lrs_pkg::result_t r;
        int unsigned      led;
        int unsigned      bit_pos;
        logic [7:0]       high_ticks;
        r = '0;
        case (it.operation)
            lrs_pkg::OP_SET:
            begin
                if (it.led_index < LEDS)
                begin
                    led_rgb[it.led_index] = {it.green, it.red, it.blue};
                    led_lit[it.led_index] = 1'b1;
                    if (it.show_after)
                        begin_frame();
                end
            end
            lrs_pkg::OP_START:
                begin_frame();
            lrs_pkg::OP_TICK:
            begin
                if (frame_on)
                begin
                    // line level from the bit of the current slot
                    if (slot_pos < DATA_SLOTS)
                    begin
                        led     = slot_pos / lrs_pkg::BITS_PER_LED;
                        bit_pos = lrs_pkg::BITS_PER_LED - 1
                                  - (slot_pos % lrs_pkg::BITS_PER_LED);
                        if (led_lit[led])
                        begin
                            high_ticks = led_rgb[led][bit_pos] ? regs.one_high_ticks
                                                               : regs.zero_high_ticks;
                            r.line_level = (slot_tick < high_ticks);
                        end
                    end
                    // advance the slot timer, close the frame after the latch gap
                    if (slot_tick >= regs.slot_period_minus_one)
                    begin
                        slot_tick = 0;
                        slot_pos++;
                        if (slot_pos >= DATA_SLOTS + regs.latch_slots)
                        begin
                            frame_on     = 1'b0;
                            slot_pos     = 0;
                            r.frame_done = 1'b1;
                        end
                    end
                    else
                    begin
                        slot_tick++;
                    end
                end
            end
            default:
                ;
        endcase
        r.busy_res = frame_on;
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin : check_results
        lrs_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (line_results_due.size() == 0)
            begin
                if (fail_count < 10)
                    $display("cycle %0d: result with none pending: line=%b busy=%b done=%b",
                             cycle_count, result.line_level, result.busy_res,
                             result.frame_done);
                fail_count++;
            end
            else
            begin
                want = line_results_due.pop_front();
                if (result.line_level !== want.line_level ||
                    result.busy_res !== want.busy_res ||
                    result.frame_done !== want.frame_done)
                begin
                    if (fail_count < 10)
                        $display("cycle %0d: expected line=%b busy=%b done=%b, got %b %b %b",
                                 cycle_count, want.line_level, want.busy_res,
                                 want.frame_done, result.line_level, result.busy_res,
                                 result.frame_done);
                    fail_count++;
                end
            end
        end
    end

    // result stall bursts
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            result_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    function automatic lrs_pkg::item_t make_item(input logic [1:0] op,
                                                 input logic [7:0] idx,
                                                 input logic [7:0] red,
                                                 input logic [7:0] green,
                                                 input logic [7:0] blue,
                                                 input logic show);
        lrs_pkg::item_t it;
        it.operation  = op;
        it.led_index  = idx;
        it.red        = red;
        it.green      = green;
        it.blue       = blue;
        it.show_after = show;
        return it;
    endfunction

    function automatic lrs_pkg::item_t rand_item(input int unsigned tick_pct);
        lrs_pkg::item_t it;
        int unsigned    pick;
        it.led_index  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, LEDS - 1));
        it.red        = 8'($urandom);
        it.green      = 8'($urandom);
        it.blue       = 8'($urandom);
        it.show_after = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < tick_pct)
            it.operation = lrs_pkg::OP_TICK;
        else
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                it.operation = lrs_pkg::OP_SET;
            else if (pick < 8)
                it.operation = lrs_pkg::OP_START;
            else
                it.operation = OP_UNUSED;
        end
        return it;
    endfunction

    // one request, with an optional idle gap in front
    task automatic send_item(input lrs_pkg::item_t it);
        int unsigned gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        line_results_due.push_back(strip_step(it));
    endtask

    task automatic wait_results_drained();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (line_results_due.size() != 0);
    endtask

    task automatic write_reg(input lrs_pkg::cfg_idx_t idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // all four registers, only with nothing in flight
    task automatic write_cfg(input lrs_pkg::cfg_t c);
        wait_results_drained();
        write_reg(lrs_pkg::CFG_PERIOD, c.slot_period_minus_one);
        write_reg(lrs_pkg::CFG_ONE_HIGH, c.one_high_ticks);
        write_reg(lrs_pkg::CFG_ZERO_HIGH, c.zero_high_ticks);
        write_reg(lrs_pkg::CFG_LATCH, c.latch_slots);
        cfg_valid <= 1'b0;
        regs = c;
    endtask

    // idle behavior, ignored requests, start while busy, changes during a frame
    task automatic test_directed();
        send_item(make_item(lrs_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_item(make_item(OP_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1));
        send_item(make_item(lrs_pkg::OP_SET, 8'd200, 8'hff, 8'hff, 8'hff, 1'b1));
        send_item(make_item(lrs_pkg::OP_SET, LEDS[7:0], 8'hff, 8'hff, 8'hff, 1'b1));
        send_item(make_item(lrs_pkg::OP_SET, 8'd0, 8'hff, 8'hff, 8'hff, 1'b0));
        send_item(make_item(lrs_pkg::OP_SET, LEDS[7:0] - 8'd1, 8'h00, 8'h00, 8'h00, 1'b0));
        send_item(make_item(lrs_pkg::OP_SET, 8'd1, 8'h5a, 8'ha5, 8'h0f, 1'b1));
        send_item(make_item(lrs_pkg::OP_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_item(make_item(lrs_pkg::OP_SET, 8'd1, 8'h3c, 8'hc3, 8'hf0, 1'b1));
        send_item(make_item(lrs_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        // retune while the frame runs
        write_cfg('{slot_period_minus_one: 8'd3, one_high_ticks: 8'd2,
                    zero_high_ticks: 8'd1, latch_slots: 8'd2});
        repeat (10) send_item(rand_item(100));
        send_item(make_item(lrs_pkg::OP_SET, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0));
        repeat (6) send_item(rand_item(100));
        send_item(make_item(OP_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    endtask

    // longest slot, run across one slot boundary
    task automatic test_slow_slots();
        write_cfg('{slot_period_minus_one: 8'd255, one_high_ticks: 8'd200,
                    zero_high_ticks: 8'd100, latch_slots: 8'd1});
        send_item(make_item(lrs_pkg::OP_SET, 8'd2, 8'h81, 8'h7e, 8'h18, 1'b1));
        repeat (280) send_item(rand_item(97));
    endtask

    // random mix over several short-slot settings, last phase without idling
    task automatic test_random();
        int unsigned p;
        for (int phase = 0; phase < 5; phase++)
        begin
            p = $urandom_range(1, 4);
            write_cfg('{slot_period_minus_one: p[7:0],
                        one_high_ticks: 8'($urandom_range(0, p + 2)),
                        zero_high_ticks: 8'($urandom_range(0, p + 2)),
                        latch_slots: 8'($urandom_range(0, 8))});
            if (phase == 4)
                idle_on = 1'b0;
            repeat (80) send_item(rand_item(70));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_slow_slots();
        test_random();
        wait_results_drained();
        repeat (4) @(posedge clk);
        if (line_results_due.size() != 0)
        begin
            $display("%0d results never arrived", line_results_due.size());
            fail_count += line_results_due.size();
        end
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lrs_pkg.sv
src/lrs_color_mem.sv
src/lrs_frame_ctrl.sv
src/rgb_led_strip_serializer.sv
dv/tb_rgb_led_strip_serializer.sv
